>>> hdl/point_segment_distance_defines.svh
// ---------------------------------------------------------------------------
// Point-to-segment distance: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_segment_distance: check failed");
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_segment_distance: check failed");
`else
`define PSD_ASSERT_IMPL(lbl, ante, cons)
`define PSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/psd_pkg.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance package
// Widths, part codes and the transaction structs shared between stages.
// ---------------------------------------------------------------------------
package psd_pkg;
  localparam int COORD_BITS = 16;
  localparam int DIST_BITS  = 21;
  localparam int W1         = COORD_BITS + 1;       // coordinate difference
  localparam int DB         = 2 * W1;               // squared length, |cross|
  localparam int HB         = DB / 2;               // half of |cross|
  localparam int QB         = 2 * DIST_BITS;        // radicand width
  localparam int NB         = QB + DB;              // dividend width
  localparam int SCALE_SH   = 8;                    // 4 extra fraction bits, squared

  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2
  } psd_part_t;

  typedef struct packed {
    logic [NB-1:0] num;
    logic [DB-1:0] den;
    psd_part_t     part;
  } psd_work_t;

  typedef struct packed {
    logic [QB-1:0] val;
    psd_part_t     part;
  } psd_root_t;
endpackage

>>> hdl/psd_if.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance channels
// Query and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface psd_in_if import psd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  query_x, query_y, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                query_x, query_y, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic [1:0]           nearest_part;
  modport source (output valid, distance, nearest_part, input ready);
  modport sink (input valid, distance, nearest_part, output ready);
endinterface

>>> hdl/point_segment_distance.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance
// Euclidean distance from a query point to a segment, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one transaction per clock: segment start, segment end and query point
// as signed 16-bit coordinates with 4 fraction bits, and returns the distance
// with 4 further fraction bits (rounded down) plus which part of the segment is
// nearest (interior, start point or end point; ties go to the start point, and
// a zero-length segment reports the start point). Throughput is one
// transaction per cycle while the result is not stalled. A transaction passes
// through the front-end stages, the 42-stage restoring divider and the 21-stage
// square root, each resolving one bit per stage. A stalled result holds the
// whole pipeline in place; req.ready follows rsp.ready combinationally.
module point_segment_distance import psd_pkg::*; (
  input  logic clk,
  input  logic rst,
  psd_in_if.sink    req,
  psd_out_if.source rsp
);
`include "point_segment_distance_defines.svh"

  logic      en;
  logic      f_valid, d_valid, s_valid;
  psd_work_t work;
  psd_root_t quot;
  psd_part_t part;

  // advance whenever the output slot is empty or being taken
  assign en        = !s_valid || rsp.ready;
  assign req.ready = en;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .ax        (req.seg_start_x),
    .ay        (req.seg_start_y),
    .bx        (req.seg_end_x),
    .by        (req.seg_end_y),
    .qx        (req.query_x),
    .qy        (req.query_y),
    .out_valid (f_valid),
    .work      (work)
  );

  // endpoint branch divides by one, so every transaction takes the same path
  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .work      (work),
    .out_valid (d_valid),
    .quot      (quot)
  );

  // final stage of the root doubles as the output register
  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .rad       (quot),
    .out_valid (s_valid),
    .root      (rsp.distance),
    .part_out  (part)
  );

  assign rsp.valid        = s_valid;
  assign rsp.nearest_part = part;

  `PSD_ASSERT_IMPL(a_part_code, rsp.valid, rsp.nearest_part != 2'd3)
  `PSD_ASSERT_IMPL(a_ready_stall, rsp.valid && !rsp.ready, !req.ready)
  `PSD_ASSERT_NEXT(a_hold_result, !req.ready, $stable(rsp.distance) && rsp.valid)
endmodule

>>> hdl/psd_front.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance front end
// Differences, products, branch choice and the dividend/divisor pair.
// ---------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  output logic                         out_valid,
  output psd_work_t                    work
);
  // stage 1: differences
  logic v1;
  logic signed [W1-1:0] dx, dy, apx, apy, bpx, bpy;
  // stage 2: products
  logic v2;
  logic signed [DB-1:0] m_dapx, m_dapy2, m_dbpx, m_dbpy, m_dxapy, m_dyapx;
  logic signed [DB-1:0] m_dxx, m_dyy, m_apxx, m_apyy, m_bpxx, m_bpyy;
  // stage 3: sums
  logic v3, interior3;
  logic [DB-1:0] cabs, len2, na, nb;
  // stage 4: square of |cross| in parts, endpoint choice
  logic v4, interior4;
  logic [DB-1:0] cll, chh, chl, len2_4, near4;
  psd_part_t part4;

  logic signed [DB:0] dot1, dot2n, cprod;
  logic [2*DB-1:0]    csq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= W1'(bx) - W1'(ax);
      dy  <= W1'(by) - W1'(ay);
      apx <= W1'(qx) - W1'(ax);
      apy <= W1'(qy) - W1'(ay);
      bpx <= W1'(qx) - W1'(bx);
      bpy <= W1'(qy) - W1'(by);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dapx  <= dx * apx;
      m_dapy2 <= dy * apy;
      m_dbpx  <= dx * bpx;
      m_dbpy  <= dy * bpy;
      m_dxapy <= dx * apy;
      m_dyapx <= dy * apx;
      m_dxx   <= dx * dx;
      m_dyy   <= dy * dy;
      m_apxx  <= apx * apx;
      m_apyy  <= apy * apy;
      m_bpxx  <= bpx * bpx;
      m_bpyy  <= bpy * bpy;
    end
  end

  always_comb begin
    dot1  = (DB+1)'(m_dapx) + (DB+1)'(m_dapy2);
    dot2n = (DB+1)'(m_dbpx) + (DB+1)'(m_dbpy);
    cprod = (DB+1)'(m_dxapy) - (DB+1)'(m_dyapx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // both dot tests strictly positive: projection falls inside
      interior3 <= !dot1[DB] && (dot1 != '0) && dot2n[DB];
      cabs      <= cprod[DB] ? DB'(-cprod) : DB'(cprod);
      len2      <= DB'(m_dxx) + DB'(m_dyy);
      na        <= DB'(m_apxx) + DB'(m_apyy);
      nb        <= DB'(m_bpxx) + DB'(m_bpyy);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      interior4 <= interior3;
      cll       <= cabs[HB-1:0] * cabs[HB-1:0];
      chh       <= cabs[DB-1:HB] * cabs[DB-1:HB];
      chl       <= cabs[DB-1:HB] * cabs[HB-1:0];
      len2_4    <= len2;
      // ties go to the start point
      near4     <= (na <= nb) ? na : nb;
      part4     <= interior3 ? PART_INTERIOR : ((na <= nb) ? PART_START : PART_END);
    end
  end

  assign csq = ((2*DB)'(chh) << (2*HB)) + ((2*DB)'(chl) << (HB+1)) + (2*DB)'(cll);

  always_ff @(posedge clk) begin
    if (en) begin
      work.num  <= interior4 ? (NB'(csq) << SCALE_SH) : (NB'(near4) << SCALE_SH);
      work.den  <= interior4 ? len2_4 : DB'(1);
      work.part <= part4;
    end
  end
endmodule

>>> hdl/psd_div.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance divider
// Restoring division, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module psd_div import psd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  psd_work_t work,
  output logic      out_valid,
  output psd_root_t quot
);
  logic          vld [0:QB];
  logic [DB-1:0] rem [0:QB];
  logic [QB-1:0] lo  [0:QB];
  logic [QB-1:0] quo [0:QB];
  logic [DB-1:0] den [0:QB];
  psd_part_t     part[0:QB];

  assign vld[0]  = in_valid;
  assign rem[0]  = work.num[NB-1:QB];
  assign lo[0]   = work.num[QB-1:0];
  assign quo[0]  = '0;
  assign den[0]  = work.den;
  assign part[0] = work.part;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DB:0] trial;
    logic        ge;
    assign trial = {rem[k], lo[k][QB-1]};
    assign ge    = trial >= {1'b0, den[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? DB'(trial - {1'b0, den[k]}) : DB'(trial);
        lo[k+1]   <= lo[k] << 1;
        quo[k+1]  <= {quo[k][QB-2:0], ge};
        den[k+1]  <= den[k];
        part[k+1] <= part[k];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quot.val  = quo[QB];
  assign quot.part = part[QB];
endmodule

>>> hdl/psd_sqrt.sv
// ---------------------------------------------------------------------------
// Point-to-segment distance square root
// Integer square root, rounded down, one result bit per pipeline stage.
// ---------------------------------------------------------------------------
module psd_sqrt import psd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  psd_root_t            rad,
  output logic                 out_valid,
  output logic [DIST_BITS-1:0] root,
  output psd_part_t            part_out
);
  logic                 vld [0:DIST_BITS];
  logic [DIST_BITS-1:0] r   [0:DIST_BITS];
  logic [QB-1:0]        val [0:DIST_BITS];
  psd_part_t            part[0:DIST_BITS];

  assign vld[0]  = in_valid;
  assign r[0]    = '0;
  assign val[0]  = rad.val;
  assign part[0] = rad.part;

  for (genvar k = 0; k < DIST_BITS; k++) begin : g_stage
    logic [DIST_BITS-1:0] trial;
    logic [QB-1:0]        sq;
    assign trial = r[k] | (DIST_BITS'(1) << (DIST_BITS - 1 - k));
    assign sq    = QB'(trial) * QB'(trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]    <= (sq <= val[k]) ? trial : r[k];
        val[k+1]  <= val[k];
        part[k+1] <= part[k];
      end
    end
  end

  assign out_valid = vld[DIST_BITS];
  assign root      = r[DIST_BITS];
  assign part_out  = part[DIST_BITS];
endmodule
